/* rtl/generational_handle_heap_gc_defines.svh */
// Assertion macros for the generational handle heap.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef GENERATIONAL_HANDLE_HEAP_GC_DEFINES_SVH
`define GENERATIONAL_HANDLE_HEAP_GC_DEFINES_SVH

// same-cycle implication
`define GHGC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GHGC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ghgc_pkg.sv */
// Shared types and constants for the generational handle heap.
// No dependencies.
package ghgc_pkg;

    localparam int MAX_RECORDS_D = 1024;
    localparam int FIELD_WORDS_D = 16384;
    localparam int MAX_FIELDS_D  = 64;
    localparam int MAX_CLASSES_D = 256;
    localparam int GEN_BITS_D    = 16;

    localparam int W_IDX  = 10;
    localparam int W_GEN  = 16;
    localparam int W_CLS  = 8;
    localparam int W_FC   = 7;
    localparam int W_SLOT = 6;
    localparam int W_WORD = 64;
    localparam int W_CCNT = 9;
    localparam int W_RECL = 10;

    localparam int REF_GEN_LSB = 10;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_READ    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_INSPECT = 3'd3,
        OP_BEGIN   = 3'd4,
        OP_MARK    = 3'd5,
        OP_SWEEP   = 3'd6,
        OP_DEFINE  = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [W_IDX-1:0]  handle_index;
        logic [W_GEN-1:0]  handle_generation;
        logic [W_CLS-1:0]  class_id;
        logic [W_FC-1:0]   field_count;
        logic [W_SLOT-1:0] slot_index;
        logic [W_WORD-1:0] write_value;
        logic              is_array;
        logic              element_is_reference;
        logic [W_WORD-1:0] reference_bits;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [W_IDX-1:0]  new_index;
        logic [W_GEN-1:0]  new_generation;
        logic [W_WORD-1:0] read_value;
        logic [W_CLS-1:0]  object_class;
        logic [W_FC-1:0]   slot_count;
        logic [W_RECL-1:0] reclaimed;
    } t_rsp;

    typedef struct packed {
        t_op  op;
        t_req req;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic pop;
    } t_bk_stat;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_AL_HEAD,
        ST_AL_REUSE,
        ST_AL_ZERO,
        ST_RES,
        ST_RD_DATA,
        ST_MCLR,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_FREE,
        ST_MK_POP,
        ST_MK_REC,
        ST_MK_CLS,
        ST_MK_FLG,
        ST_MK_SLOT,
        ST_MK_WORD,
        ST_MK_TGT
    } t_state;

endpackage

/* rtl/ghgc_front.sv */
// Command front end: decodes request words and holds them in a short queue.
// Depends on ghgc_pkg.
module ghgc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ghgc_pkg::t_req    i_req,
    input  ghgc_pkg::t_bk_stat i_stat,
    output logic              o_cmd_vld,
    output ghgc_pkg::t_cmd    o_cmd
);

    localparam int PW = (ghgc_pkg::QUEUE_DEPTH > 1) ? $clog2(ghgc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(ghgc_pkg::QUEUE_DEPTH + 1);

    ghgc_pkg::t_cmd r_q [ghgc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    ghgc_pkg::t_op  op;
    logic           push;
    logic           pop;

    assign op = ghgc_pkg::t_op'(i_req.req_type);

    assign o_busy    = (r_cnt == CW'(ghgc_pkg::QUEUE_DEPTH)) || !i_stat.ready;
    assign push      = i_start && !o_busy;
    assign pop       = i_stat.pop && (r_cnt != '0);
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PW'(ghgc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (pop) begin
            n_rp = (r_rp == PW'(ghgc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: op, req: i_req};
        end
    end

endmodule

/* rtl/ghgc_back.sv */
// Command back end: record, field, free-list, grey-stack and class memories
// with the sequencer for allocate, access, mark and sweep. Depends on ghgc_pkg.
module ghgc_back #(
    parameter int MAX_RECORDS = ghgc_pkg::MAX_RECORDS_D,
    parameter int FIELD_WORDS = ghgc_pkg::FIELD_WORDS_D,
    parameter int MAX_FIELDS  = ghgc_pkg::MAX_FIELDS_D,
    parameter int MAX_CLASSES = ghgc_pkg::MAX_CLASSES_D,
    parameter int GEN_BITS    = ghgc_pkg::GEN_BITS_D
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ghgc_pkg::W_CCNT-1:0]  i_cfg_data,
    input  logic                         i_cmd_vld,
    input  ghgc_pkg::t_cmd               i_cmd,
    output ghgc_pkg::t_bk_stat           o_stat,
    output logic                         o_valid,
    output ghgc_pkg::t_rsp               o_rsp
);

    localparam int RI     = $clog2(MAX_RECORDS);
    localparam int NW     = $clog2(MAX_RECORDS + 1);
    localparam int FI     = $clog2(FIELD_WORDS);
    localparam int FB     = $clog2(FIELD_WORDS + 1);
    localparam int FS     = FB + 1;
    localparam int HI     = $clog2(MAX_FIELDS + 1);
    localparam int CI     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int INIT_N = (MAX_CLASSES > MAX_FIELDS + 1) ? MAX_CLASSES : MAX_FIELDS + 1;
    localparam int IW     = $clog2(INIT_N + 1);

    typedef struct packed {
        logic                       live;
        logic [GEN_BITS-1:0]        gen;
        logic [ghgc_pkg::W_CLS-1:0] cls;
        logic [FB-1:0]              base;
        logic [ghgc_pkg::W_FC-1:0]  cnt;
    } t_rec;

    typedef struct packed {
        logic                        elem_ref;
        logic                        seq;
        logic [ghgc_pkg::W_WORD-1:0] bits;
    } t_cls;

    function automatic logic [FI-1:0] fw_addr(input logic [FB-1:0] base,
                                              input logic [ghgc_pkg::W_FC-1:0] off);
        logic [FS-1:0] s;
        s = {1'b0, base} + FS'(off);
        if (s >= FS'(FIELD_WORDS)) begin
            s = s - FS'(FIELD_WORDS);
        end
        return FI'(s);
    endfunction

    function automatic logic [GEN_BITS-1:0] gen_next(input logic [GEN_BITS-1:0] g);
        logic [GEN_BITS-1:0] n;
        n = g + GEN_BITS'(1);
        if (n == '0) begin
            n = GEN_BITS'(1);
        end
        return n;
    endfunction

    t_rec                        r_rec_mem  [MAX_RECORDS];
    logic                        r_mk_mem   [MAX_RECORDS];
    logic [RI-1:0]               r_fl_mem   [MAX_RECORDS];
    logic [RI-1:0]               r_gs_mem   [MAX_RECORDS];
    logic [ghgc_pkg::W_WORD-1:0] r_fw_mem   [FIELD_WORDS];
    logic [RI-1:0]               r_fh_mem   [MAX_FIELDS + 1];
    t_cls                        r_cl_mem   [MAX_CLASSES];

    t_rec                        r_rec_rd;
    logic                        r_mk_rd;
    logic [RI-1:0]               r_fl_rd;
    logic [RI-1:0]               r_gs_rd;
    logic [ghgc_pkg::W_WORD-1:0] r_fw_rd;
    logic [RI-1:0]               r_fh_rd;
    t_cls                        r_cl_rd;

    logic rec_we, mk_we, mk_wd, fl_we, gs_we, fw_we, fh_we, cl_we;
    logic [RI-1:0] rec_wa, rec_ra, mk_wa, mk_ra, fl_wa, fl_ra, fl_wd, gs_wa, gs_ra, gs_wd;
    logic [RI-1:0] fh_wd;
    t_rec          rec_wd;
    logic [FI-1:0] fw_wa, fw_ra;
    logic [ghgc_pkg::W_WORD-1:0] fw_wd;
    logic [HI-1:0] fh_wa, fh_ra;
    logic [CI-1:0] cl_wa, cl_ra;
    t_cls          cl_wd;

    ghgc_pkg::t_state          r_state, n_state;
    ghgc_pkg::t_cmd            r_cmd, n_cmd;
    logic [NW-1:0]             r_nrec, n_nrec;
    logic [FB-1:0]             r_nfw, n_nfw;
    logic [ghgc_pkg::W_CCNT-1:0] r_ccount;
    logic [RI-1:0]             r_idx, n_idx;
    t_rec                      r_rec, n_rec;
    t_cls                      r_cls, n_cls;
    logic [ghgc_pkg::W_FC-1:0] r_cnt, n_cnt;
    logic [NW-1:0]             r_i, n_i;
    logic [NW-1:0]             r_depth, n_depth;
    logic [ghgc_pkg::W_GEN-1:0] r_tgen, n_tgen;
    logic [ghgc_pkg::W_RECL-1:0] r_recl, n_recl;
    logic [IW-1:0]             r_init, n_init;
    logic                      r_valid, n_valid;
    ghgc_pkg::t_rsp            r_rsp, n_rsp;
    logic                      pop;

    assign o_stat  = '{ready: (r_state != ghgc_pkg::ST_INIT), pop: pop};
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        ghgc_pkg::t_rsp rv;
        t_rec           rec_v;
        logic           fin;
        logic [ghgc_pkg::W_IDX-1:0] tidx;

        rv    = '0;
        rec_v = r_rec_rd;
        fin   = 1'b0;
        tidx  = r_fw_rd[ghgc_pkg::W_IDX-1:0];

        n_state = r_state;
        n_cmd   = r_cmd;
        n_nrec  = r_nrec;
        n_nfw   = r_nfw;
        n_idx   = r_idx;
        n_rec   = r_rec;
        n_cls   = r_cls;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_depth = r_depth;
        n_tgen  = r_tgen;
        n_recl  = r_recl;
        n_init  = r_init;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        pop     = 1'b0;

        rec_we = 1'b0; rec_wa = '0; rec_wd = r_rec; rec_ra = '0;
        mk_we  = 1'b0; mk_wa  = '0; mk_wd  = 1'b0;  mk_ra  = '0;
        fl_we  = 1'b0; fl_wa  = '0; fl_wd  = '0;    fl_ra  = '0;
        gs_we  = 1'b0; gs_wa  = '0; gs_wd  = '0;    gs_ra  = '0;
        fw_we  = 1'b0; fw_wa  = '0; fw_wd  = '0;    fw_ra  = '0;
        fh_we  = 1'b0; fh_wa  = '0; fh_wd  = '0;    fh_ra  = '0;
        cl_we  = 1'b0; cl_wa  = '0; cl_wd  = '0;    cl_ra  = '0;

        unique case (r_state)
            ghgc_pkg::ST_INIT: begin
                cl_we  = (32'(r_init) < MAX_CLASSES);
                cl_wa  = CI'(r_init);
                fh_we  = (32'(r_init) <= MAX_FIELDS);
                fh_wa  = HI'(r_init);
                n_init = r_init + IW'(1);
                if (32'(r_init) == INIT_N - 1) begin
                    n_state = ghgc_pkg::ST_IDLE;
                end
            end
            ghgc_pkg::ST_IDLE: begin
                if (i_cmd_vld) begin
                    pop   = 1'b1;
                    n_cmd = i_cmd;
                    unique case (i_cmd.op) inside
                        ghgc_pkg::OP_ALLOC: begin
                            if (32'(i_cmd.req.field_count) > MAX_FIELDS) begin
                                fin = 1'b1;
                            end else begin
                                fh_ra   = HI'(i_cmd.req.field_count);
                                n_state = ghgc_pkg::ST_AL_HEAD;
                            end
                        end
                        ghgc_pkg::OP_READ, ghgc_pkg::OP_WRITE,
                        ghgc_pkg::OP_INSPECT, ghgc_pkg::OP_MARK: begin
                            if (i_cmd.req.handle_index == '0 ||
                                32'(i_cmd.req.handle_index) >= 32'(r_nrec)) begin
                                fin = 1'b1;
                            end else begin
                                rec_ra  = RI'(i_cmd.req.handle_index);
                                mk_ra   = RI'(i_cmd.req.handle_index);
                                n_idx   = RI'(i_cmd.req.handle_index);
                                n_state = ghgc_pkg::ST_RES;
                            end
                        end
                        ghgc_pkg::OP_BEGIN: begin
                            n_i     = '0;
                            n_state = ghgc_pkg::ST_MCLR;
                        end
                        ghgc_pkg::OP_SWEEP: begin
                            n_i     = NW'(1);
                            n_recl  = '0;
                            n_state = ghgc_pkg::ST_SW_RD;
                        end
                        ghgc_pkg::OP_DEFINE: begin
                            cl_we = (32'(i_cmd.req.class_id) < MAX_CLASSES);
                            cl_wa = CI'(i_cmd.req.class_id);
                            cl_wd = '{elem_ref: i_cmd.req.element_is_reference,
                                      seq:      i_cmd.req.is_array,
                                      bits:     i_cmd.req.reference_bits};
                            rv.ok = 1'b1;
                            fin   = 1'b1;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            ghgc_pkg::ST_AL_HEAD: begin
                if (r_fh_rd != '0) begin
                    n_idx   = r_fh_rd;
                    fl_ra   = r_fh_rd;
                    rec_ra  = r_fh_rd;
                    n_state = ghgc_pkg::ST_AL_REUSE;
                end else if (32'(r_nrec) >= MAX_RECORDS ||
                             32'(r_nfw) + 32'(r_cmd.req.field_count) > FIELD_WORDS) begin
                    fin = 1'b1;
                end else begin
                    rec_v.live = 1'b1;
                    rec_v.gen  = GEN_BITS'(1);
                    rec_v.cls  = r_cmd.req.class_id;
                    rec_v.base = r_nfw;
                    rec_v.cnt  = r_cmd.req.field_count;
                    rec_we  = 1'b1;
                    rec_wa  = RI'(r_nrec);
                    rec_wd  = rec_v;
                    mk_we   = 1'b1;
                    mk_wa   = RI'(r_nrec);
                    n_idx   = RI'(r_nrec);
                    n_rec   = rec_v;
                    n_nrec  = r_nrec + NW'(1);
                    n_nfw   = r_nfw + FB'(r_cmd.req.field_count);
                    n_cnt   = '0;
                    n_state = ghgc_pkg::ST_AL_ZERO;
                end
            end
            ghgc_pkg::ST_AL_REUSE: begin
                fh_we = 1'b1;
                fh_wa = HI'(r_cmd.req.field_count);
                fh_wd = r_fl_rd;
                rec_v.live = 1'b1;
                rec_v.cls  = r_cmd.req.class_id;
                if (rec_v.gen == '0) begin
                    rec_v.gen = GEN_BITS'(1);
                end
                rec_we  = 1'b1;
                rec_wa  = r_idx;
                rec_wd  = rec_v;
                mk_we   = 1'b1;
                mk_wa   = r_idx;
                n_rec   = rec_v;
                n_cnt   = '0;
                n_state = ghgc_pkg::ST_AL_ZERO;
            end
            ghgc_pkg::ST_AL_ZERO: begin
                if (r_cnt < r_rec.cnt) begin
                    fw_we = 1'b1;
                    fw_wa = fw_addr(r_rec.base, r_cnt);
                    n_cnt = r_cnt + ghgc_pkg::W_FC'(1);
                end else begin
                    rv.ok             = 1'b1;
                    rv.new_index      = ghgc_pkg::W_IDX'(r_idx);
                    rv.new_generation = ghgc_pkg::W_GEN'(r_rec.gen);
                    fin               = 1'b1;
                end
            end
            ghgc_pkg::ST_RES: begin
                if (!r_rec_rd.live ||
                    32'(r_rec_rd.gen) != 32'(r_cmd.req.handle_generation)) begin
                    fin = 1'b1;
                end else begin
                    unique case (r_cmd.op) inside
                        ghgc_pkg::OP_INSPECT: begin
                            rv.ok           = 1'b1;
                            rv.object_class = r_rec_rd.cls;
                            rv.slot_count   = r_rec_rd.cnt;
                            fin             = 1'b1;
                        end
                        ghgc_pkg::OP_READ: begin
                            if (ghgc_pkg::W_FC'(r_cmd.req.slot_index) >= r_rec_rd.cnt) begin
                                fin = 1'b1;
                            end else begin
                                fw_ra   = fw_addr(r_rec_rd.base,
                                                  ghgc_pkg::W_FC'(r_cmd.req.slot_index));
                                n_state = ghgc_pkg::ST_RD_DATA;
                            end
                        end
                        ghgc_pkg::OP_WRITE: begin
                            if (ghgc_pkg::W_FC'(r_cmd.req.slot_index) < r_rec_rd.cnt) begin
                                fw_we = 1'b1;
                                fw_wa = fw_addr(r_rec_rd.base,
                                                ghgc_pkg::W_FC'(r_cmd.req.slot_index));
                                fw_wd = r_cmd.req.write_value;
                                rv.ok = 1'b1;
                            end
                            fin = 1'b1;
                        end
                        ghgc_pkg::OP_MARK: begin
                            if (r_mk_rd) begin
                                rv.ok = 1'b1;
                                fin   = 1'b1;
                            end else begin
                                mk_we   = 1'b1;
                                mk_wa   = r_idx;
                                mk_wd   = 1'b1;
                                gs_we   = 1'b1;
                                gs_wa   = '0;
                                gs_wd   = r_idx;
                                n_depth = NW'(1);
                                n_state = ghgc_pkg::ST_MK_POP;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            ghgc_pkg::ST_RD_DATA: begin
                rv.ok         = 1'b1;
                rv.read_value = r_fw_rd;
                fin           = 1'b1;
            end
            ghgc_pkg::ST_MCLR: begin
                if (r_i < r_nrec) begin
                    mk_we = 1'b1;
                    mk_wa = RI'(r_i);
                    n_i   = r_i + NW'(1);
                end else begin
                    rv.ok = 1'b1;
                    fin   = 1'b1;
                end
            end
            ghgc_pkg::ST_SW_RD: begin
                if (r_i >= r_nrec) begin
                    rv.ok        = 1'b1;
                    rv.reclaimed = r_recl;
                    fin          = 1'b1;
                end else begin
                    rec_ra  = RI'(r_i);
                    mk_ra   = RI'(r_i);
                    n_state = ghgc_pkg::ST_SW_CHK;
                end
            end
            ghgc_pkg::ST_SW_CHK: begin
                if (r_rec_rd.live && !r_mk_rd) begin
                    rec_v.live = 1'b0;
                    rec_v.gen  = gen_next(r_rec_rd.gen);
                    n_rec      = rec_v;
                    fh_ra      = HI'(r_rec_rd.cnt);
                    n_state    = ghgc_pkg::ST_SW_FREE;
                end else begin
                    n_i     = r_i + NW'(1);
                    n_state = ghgc_pkg::ST_SW_RD;
                end
            end
            ghgc_pkg::ST_SW_FREE: begin
                rec_we  = 1'b1;
                rec_wa  = RI'(r_i);
                rec_wd  = r_rec;
                fl_we   = (32'(r_rec.cnt) <= MAX_FIELDS);
                fl_wa   = RI'(r_i);
                fl_wd   = r_fh_rd;
                fh_we   = (32'(r_rec.cnt) <= MAX_FIELDS);
                fh_wa   = HI'(r_rec.cnt);
                fh_wd   = RI'(r_i);
                n_recl  = r_recl + ghgc_pkg::W_RECL'(1);
                n_i     = r_i + NW'(1);
                n_state = ghgc_pkg::ST_SW_RD;
            end
            ghgc_pkg::ST_MK_POP: begin
                if (r_depth == '0) begin
                    rv.ok = 1'b1;
                    fin   = 1'b1;
                end else begin
                    n_depth = r_depth - NW'(1);
                    gs_ra   = RI'(r_depth - NW'(1));
                    n_state = ghgc_pkg::ST_MK_REC;
                end
            end
            ghgc_pkg::ST_MK_REC: begin
                rec_ra  = r_gs_rd;
                n_state = ghgc_pkg::ST_MK_CLS;
            end
            ghgc_pkg::ST_MK_CLS: begin
                n_rec = r_rec_rd;
                if (32'(r_rec_rd.cls) >= 32'(r_ccount) ||
                    32'(r_rec_rd.cls) >= MAX_CLASSES) begin
                    n_state = ghgc_pkg::ST_MK_POP;
                end else begin
                    cl_ra   = CI'(r_rec_rd.cls);
                    n_state = ghgc_pkg::ST_MK_FLG;
                end
            end
            ghgc_pkg::ST_MK_FLG: begin
                n_cls = r_cl_rd;
                if (r_cl_rd.seq && !r_cl_rd.elem_ref) begin
                    n_state = ghgc_pkg::ST_MK_POP;
                end else begin
                    n_cnt   = '0;
                    n_state = ghgc_pkg::ST_MK_SLOT;
                end
            end
            ghgc_pkg::ST_MK_SLOT: begin
                if (r_cnt < r_rec.cnt && r_cnt < ghgc_pkg::W_FC'(ghgc_pkg::W_WORD)) begin
                    n_cnt = r_cnt + ghgc_pkg::W_FC'(1);
                    if (r_cls.seq || r_cls.bits[r_cnt[ghgc_pkg::W_SLOT-1:0]]) begin
                        fw_ra   = fw_addr(r_rec.base, r_cnt);
                        n_state = ghgc_pkg::ST_MK_WORD;
                    end
                end else begin
                    n_state = ghgc_pkg::ST_MK_POP;
                end
            end
            ghgc_pkg::ST_MK_WORD: begin
                if (tidx == '0 || 32'(tidx) >= 32'(r_nrec)) begin
                    n_state = ghgc_pkg::ST_MK_SLOT;
                end else begin
                    rec_ra  = RI'(tidx);
                    mk_ra   = RI'(tidx);
                    n_idx   = RI'(tidx);
                    n_tgen  = r_fw_rd[ghgc_pkg::REF_GEN_LSB +: ghgc_pkg::W_GEN];
                    n_state = ghgc_pkg::ST_MK_TGT;
                end
            end
            ghgc_pkg::ST_MK_TGT: begin
                if (r_rec_rd.live && 32'(r_rec_rd.gen) == 32'(r_tgen) && !r_mk_rd) begin
                    mk_we = 1'b1;
                    mk_wa = r_idx;
                    mk_wd = 1'b1;
                    if (32'(r_depth) < MAX_RECORDS) begin
                        gs_we   = 1'b1;
                        gs_wa   = RI'(r_depth);
                        gs_wd   = r_idx;
                        n_depth = r_depth + NW'(1);
                    end
                end
                n_state = ghgc_pkg::ST_MK_SLOT;
            end
            default: n_state = ghgc_pkg::ST_IDLE;
        endcase

        if (fin) begin
            n_valid = 1'b1;
            n_rsp   = rv;
            n_state = ghgc_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ghgc_pkg::ST_INIT;
            r_nrec   <= NW'(1);
            r_nfw    <= '0;
            r_ccount <= '0;
            r_init   <= '0;
            r_valid  <= 1'b0;
            r_depth  <= '0;
        end else begin
            r_state <= n_state;
            r_nrec  <= n_nrec;
            r_nfw   <= n_nfw;
            r_init  <= n_init;
            r_valid <= n_valid;
            r_depth <= n_depth;
            if (i_cfg_we) begin
                r_ccount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_rec  <= n_rec;
        r_cls  <= n_cls;
        r_cnt  <= n_cnt;
        r_i    <= n_i;
        r_tgen <= n_tgen;
        r_recl <= n_recl;
        r_rsp  <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[rec_wa] <= rec_wd;
        end
        r_rec_rd <= r_rec_mem[rec_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mk_mem[mk_wa] <= mk_wd;
        end
        r_mk_rd <= r_mk_mem[mk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_fl_mem[fl_wa] <= fl_wd;
        end
        r_fl_rd <= r_fl_mem[fl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (gs_we) begin
            r_gs_mem[gs_wa] <= gs_wd;
        end
        r_gs_rd <= r_gs_mem[gs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fw_we) begin
            r_fw_mem[fw_wa] <= fw_wd;
        end
        r_fw_rd <= r_fw_mem[fw_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fh_we) begin
            r_fh_mem[fh_wa] <= fh_wd;
        end
        r_fh_rd <= r_fh_mem[fh_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cl_we) begin
            r_cl_mem[cl_wa] <= cl_wd;
        end
        r_cl_rd <= r_cl_mem[cl_ra];
    end

endmodule

/* rtl/generational_handle_heap_gc.sv */
// Object heap with generation-checked handles and a mark-sweep collector.
// Commands enter through a two-entry queue that is accepted while the sequencer
// works, so start may be taken during a running command. Each command returns one
// result, shown for one cycle with o_valid; the receiver cannot stall it. All work
// goes through single-port record, field-word, free-list, grey-stack and class
// memories, one access per cycle: allocate zeroes each new field word, begin
// collection clears the mark of each issued record, sweep frees each live unmarked
// record, and mark traces reference slots from the root through the grey stack.
// After reset a clearing pass over the class and free-list head memories holds busy.
// Depends on ghgc_pkg, ghgc_front, ghgc_back and the assertion macro header.
`include "generational_handle_heap_gc_defines.svh"

module generational_handle_heap_gc #(
    parameter int MAX_RECORDS = ghgc_pkg::MAX_RECORDS_D,
    parameter int FIELD_WORDS = ghgc_pkg::FIELD_WORDS_D,
    parameter int MAX_FIELDS  = ghgc_pkg::MAX_FIELDS_D,
    parameter int MAX_CLASSES = ghgc_pkg::MAX_CLASSES_D,
    parameter int GEN_BITS    = ghgc_pkg::GEN_BITS_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ghgc_pkg::t_req              i_req,
    input  logic                        i_cfg_we,
    input  logic [ghgc_pkg::W_CCNT-1:0] i_cfg_data,
    output logic                        o_valid,
    output ghgc_pkg::t_rsp              o_rsp
);

    ghgc_pkg::t_bk_stat bk_stat;
    ghgc_pkg::t_cmd     cmd;
    logic               cmd_vld;

    ghgc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_req     (i_req),
        .i_stat    (bk_stat),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd)
    );

    ghgc_back #(
        .MAX_RECORDS (MAX_RECORDS),
        .FIELD_WORDS (FIELD_WORDS),
        .MAX_FIELDS  (MAX_FIELDS),
        .MAX_CLASSES (MAX_CLASSES),
        .GEN_BITS    (GEN_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_stat     (bk_stat),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

    `GHGC_ASSERT_IMP(a_init_busy, !bk_stat.ready, busy, "clearing pass without busy")
    `GHGC_ASSERT_NXT(a_ready_holds, bk_stat.ready, bk_stat.ready, "sequencer fell back to clear")
    `GHGC_ASSERT_IMP(a_fail_zero, o_valid && !o_rsp.ok, o_rsp.new_index == '0 && o_rsp.read_value == '0 && o_rsp.reclaimed == '0, "failed result carries payload")
    `GHGC_ASSERT_IMP(a_alloc_gen, o_valid && o_rsp.new_index != '0, o_rsp.ok && o_rsp.new_generation != '0, "allocated handle with zero generation")

endmodule
